>>> design/imf_pkg.sv
// shared types, constants and helpers for the 3x3 minimum filter
// no dependencies; used by every module of the block
package imf_pkg;

   localparam int CHAN_W      = 8;
   localparam int PIX_W       = 3 * CHAN_W;
   localparam int ROW_W       = 16;
   localparam int COL_W       = 10;
   localparam int WID_W       = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR_MODE   = 2'd2;

   localparam logic [ROW_W-1:0] RESET_HEIGHT = 16'd480;
   localparam logic             RESET_COLOR  = 1'b1;

   typedef struct packed {
      logic              command;
      logic [CHAN_W-1:0] pixel_red;
      logic [CHAN_W-1:0] pixel_green;
      logic [CHAN_W-1:0] pixel_blue;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
      logic [ROW_W-1:0]  out_row;
      logic [COL_W-1:0]  out_col;
      logic              last_of_frame;
   } rsp_type;

   // one classified item handed from front to back
   typedef struct packed {
      logic             shift;     // pixel: push column into window
      logic [PIX_W-1:0] colmin;    // channel-wise min of the column {b,g,r}
      logic             o1;        // emit (row, o1_col)
      logic             o1_zero;   // border output, value forced to 0
      logic [COL_W-1:0] o1_col;
      logic             o1_last;
      logic             o2;        // end-of-row border output
      logic [COL_W-1:0] o2_col;
      logic [ROW_W-1:0] row;
   } job_type;

   typedef enum logic {
      PHASE_FIRST,
      PHASE_SECOND
   } back_phase_type;

   function automatic logic [CHAN_W-1:0] min2(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
      min2 = (a < b) ? a : b;
   endfunction

   // channel-wise minimum of three packed pixels
   function automatic logic [PIX_W-1:0] min3_pix(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b,
                                                 input logic [PIX_W-1:0] c);
      logic [PIX_W-1:0] res;
      for (int k = 0; k < 3; k++) begin
         res[k*CHAN_W +: CHAN_W] = min2(min2(a[k*CHAN_W +: CHAN_W], b[k*CHAN_W +: CHAN_W]),
                                        c[k*CHAN_W +: CHAN_W]);
      end
      min3_pix = res;
   endfunction

endpackage

>>> design/imf_front.sv
// front end: registers, raster counters, line buffer and column minimum
// uses imf_pkg; feeds imf_queue
module imf_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  imf_pkg::req_type                req_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [imf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [imf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [imf_pkg::QCNT_W-1:0]      q_count,
   output logic                            q_push,
   output imf_pkg::job_type                q_push_job
);

   localparam int AW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RESET_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
   localparam int LINE_W  = 2 * imf_pkg::PIX_W;

   // both line buffers side by side: {two rows above, row above}
   logic [LINE_W-1:0] line_mem [MAX_WIDTH];

   logic [imf_pkg::WID_W-1:0] width_ff, width_in;
   logic [imf_pkg::ROW_W-1:0] height_ff, height_in;
   logic                      color_ff, color_in;
   logic [imf_pkg::ROW_W-1:0] row_ff, row_in;
   logic [imf_pkg::WID_W-1:0] col_ff, col_in;
   logic [imf_pkg::WID_W-1:0] drain_ff, drain_in;

   logic                      s1_valid_ff, s1_valid_in;
   imf_pkg::job_type          s1_job_ff, s1_job_in;
   logic [imf_pkg::PIX_W-1:0] s1_pix_ff, s1_pix_in;
   logic [AW-1:0]             s1_addr_ff;
   logic                      s1_fwd_ff, s1_fwd_in;
   logic [LINE_W-1:0]         s1_fwd_data_ff;
   logic [LINE_W-1:0]         rd_ff;

   logic                      accept;
   logic                      pixel_go;
   logic                      drain_go;
   logic                      last_col;
   logic [AW-1:0]             addr_new;
   logic [LINE_W-1:0]         line_eff;
   logic [LINE_W-1:0]         wr_data;
   logic [imf_pkg::QCNT_W:0]  occupancy;
   logic [imf_pkg::WID_W-1:0] w_clamped;
   logic [imf_pkg::ROW_W-1:0] h_clamped;
   logic [imf_pkg::WID_W-1:0] wval;

   assign csr_ready = 1'b1;

   // item in s1 still needs a queue slot
   assign occupancy = {1'b0, q_count} + (imf_pkg::QCNT_W + 1)'(s1_valid_ff);
   assign req_stall = (32'(occupancy) >= imf_pkg::QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;

   assign pixel_go = accept && (req_data.command == imf_pkg::CMD_PIXEL)
                     && (row_ff < height_ff) && (col_ff < width_ff);
   assign drain_go = accept && (req_data.command == imf_pkg::CMD_DRAIN)
                     && (row_ff >= height_ff) && (drain_ff < width_ff);
   assign last_col = (col_ff == width_ff - imf_pkg::WID_W'(1));
   assign addr_new = AW'(col_ff);

   // read data of s1, corrected when the previous beat wrote the same entry
   assign line_eff = s1_fwd_ff ? s1_fwd_data_ff : rd_ff;
   assign wr_data  = {line_eff[imf_pkg::PIX_W-1:0], s1_pix_ff};

   assign wval = csr_wdata[imf_pkg::WID_W-1:0];

   always_comb begin
      if (wval == '0) begin
         w_clamped = imf_pkg::WID_W'(1);
      end else if (32'(wval) > MAX_WIDTH) begin
         w_clamped = imf_pkg::WID_W'(MAX_WIDTH);
      end else begin
         w_clamped = wval;
      end
      h_clamped = (csr_wdata == '0) ? imf_pkg::ROW_W'(1) : csr_wdata;
   end

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      color_in    = color_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      drain_in    = drain_ff;
      s1_valid_in = 1'b0;
      s1_job_in   = '0;
      s1_pix_in   = color_ff ? {req_data.pixel_blue, req_data.pixel_green, req_data.pixel_red}
                             : {16'd0, req_data.pixel_red};
      s1_fwd_in   = s1_valid_ff && s1_job_ff.shift && (s1_addr_ff == addr_new);

      if (pixel_go) begin
         s1_valid_in       = 1'b1;
         s1_job_in.shift   = 1'b1;
         s1_job_in.o1      = (row_ff != '0) && (col_ff != '0);
         s1_job_in.o1_zero = (row_ff < imf_pkg::ROW_W'(2)) || (col_ff < imf_pkg::WID_W'(2));
         s1_job_in.o1_col  = imf_pkg::COL_W'(col_ff - imf_pkg::WID_W'(1));
         s1_job_in.o2      = (row_ff != '0) && last_col;
         s1_job_in.o2_col  = imf_pkg::COL_W'(width_ff - imf_pkg::WID_W'(1));
         s1_job_in.row     = row_ff - imf_pkg::ROW_W'(1);
         if (last_col) begin
            col_in = '0;
            row_in = row_ff + imf_pkg::ROW_W'(1);
         end else begin
            col_in = col_ff + imf_pkg::WID_W'(1);
         end
      end else if (drain_go) begin
         s1_valid_in       = 1'b1;
         s1_job_in.o1      = 1'b1;
         s1_job_in.o1_zero = 1'b1;
         s1_job_in.o1_col  = imf_pkg::COL_W'(drain_ff);
         s1_job_in.o1_last = (drain_ff == width_ff - imf_pkg::WID_W'(1));
         s1_job_in.row     = height_ff - imf_pkg::ROW_W'(1);
         if (drain_ff == width_ff - imf_pkg::WID_W'(1)) begin
            row_in   = '0;
            col_in   = '0;
            drain_in = '0;
         end else begin
            drain_in = drain_ff + imf_pkg::WID_W'(1);
         end
      end

      if (csr_valid) begin
         case (csr_index)
            imf_pkg::REG_IMAGE_WIDTH: begin
               width_in = w_clamped;
               row_in   = '0;
               col_in   = '0;
               drain_in = '0;
            end
            imf_pkg::REG_IMAGE_HEIGHT: begin
               height_in = h_clamped;
               row_in    = '0;
               col_in    = '0;
               drain_in  = '0;
            end
            imf_pkg::REG_COLOR_MODE: begin
               color_in = csr_wdata[0];
               row_in   = '0;
               col_in   = '0;
               drain_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= imf_pkg::WID_W'(RESET_W);
         height_ff   <= imf_pkg::RESET_HEIGHT;
         color_ff    <= imf_pkg::RESET_COLOR;
         row_ff      <= '0;
         col_ff      <= '0;
         drain_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         color_ff    <= color_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         drain_ff    <= drain_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_job_ff      <= s1_job_in;
      s1_pix_ff      <= s1_pix_in;
      s1_addr_ff     <= addr_new;
      s1_fwd_ff      <= s1_fwd_in;
      s1_fwd_data_ff <= wr_data;
   end

   // line buffer: one read for each accepted pixel, the shifted entry written back in s1
   always_ff @(posedge clock) begin
      if (pixel_go) begin
         rd_ff <= line_mem[addr_new];
      end
      if (s1_valid_ff && s1_job_ff.shift) begin
         line_mem[s1_addr_ff] <= wr_data;
      end
   end

   always_comb begin
      q_push            = s1_valid_ff;
      q_push_job        = s1_job_ff;
      q_push_job.colmin = imf_pkg::min3_pix(line_eff[LINE_W-1:imf_pkg::PIX_W],
                                            line_eff[imf_pkg::PIX_W-1:0], s1_pix_ff);
   end

endmodule

>>> design/imf_queue.sv
// short job queue between front and back ends
// uses imf_pkg for the job type and depth
module imf_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  imf_pkg::job_type            push_job,
   input  logic                        pop,
   output imf_pkg::job_type            head,
   output logic                        empty,
   output logic [imf_pkg::QCNT_W-1:0]  count
);

   imf_pkg::job_type entries_ff [imf_pkg::QUEUE_DEPTH];

   logic [imf_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [imf_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [imf_pkg::QCNT_W-1:0] count_ff, count_in;

   assign head  = entries_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + imf_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + imf_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + imf_pkg::QCNT_W'(push) - imf_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> design/imf_back.sv
// back end: 3-column window of column minima and result register
// uses imf_pkg; drains imf_queue
module imf_back (
   input  logic              clock,
   input  logic              reset,
   input  imf_pkg::job_type  head,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output imf_pkg::rsp_type  rsp_data
);

   imf_pkg::back_phase_type phase_ff, phase_in;

   // column minima of columns c-2 and c-1
   logic [imf_pkg::PIX_W-1:0] win_old_ff, win_new_ff;
   logic                      shift;
   logic                      rsp_valid_ff, rsp_valid_in;
   imf_pkg::rsp_type          rsp_data_ff, rsp_data_in;
   logic                      slot_free;
   logic                      emit;
   logic [imf_pkg::PIX_W-1:0] win_min;
   logic [imf_pkg::PIX_W-1:0] val1;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign win_min   = imf_pkg::min3_pix(win_old_ff, win_new_ff, head.colmin);
   assign val1      = head.o1_zero ? '0 : win_min;

   always_comb begin
      phase_in    = phase_ff;
      q_pop       = 1'b0;
      shift       = 1'b0;
      emit        = 1'b0;
      rsp_data_in = rsp_data_ff;

      case (phase_ff)
         imf_pkg::PHASE_FIRST: begin
            if (!q_empty) begin
               if (head.o1) begin
                  if (slot_free) begin
                     emit        = 1'b1;
                     shift       = head.shift;
                     rsp_data_in = {val1[7:0], val1[15:8], val1[23:16],
                                    head.row, head.o1_col, head.o1_last};
                     if (head.o2) begin
                        phase_in = imf_pkg::PHASE_SECOND;
                     end else begin
                        q_pop = 1'b1;
                     end
                  end
               end else if (head.o2) begin
                  if (slot_free) begin
                     emit        = 1'b1;
                     shift       = head.shift;
                     q_pop       = 1'b1;
                     rsp_data_in = {24'd0, head.row, head.o2_col, 1'b0};
                  end
               end else begin
                  shift = head.shift;
                  q_pop = 1'b1;
               end
            end
         end
         imf_pkg::PHASE_SECOND: begin
            // window already shifted with the first beat
            if (slot_free) begin
               emit        = 1'b1;
               q_pop       = 1'b1;
               phase_in    = imf_pkg::PHASE_FIRST;
               rsp_data_in = {24'd0, head.row, head.o2_col, 1'b0};
            end
         end
         default: begin
            phase_in = imf_pkg::PHASE_FIRST;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= imf_pkg::PHASE_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (shift) begin
         win_old_ff <= win_new_ff;
         win_new_ff <= head.colmin;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> design/image_min_filter_3x3_unit.sv
// 3x3 minimum filter on a raster pixel stream, zero-padded border.
// One pixel or drain beat is taken every clock while req_stall is low; the last pixel of
// each row (from the second row on) makes two result beats, which can hold the input
// once the queue fills. The line buffer is one memory of MAX_WIDTH entries with one
// read and one write port per clock. An accepted pixel reaches its result beat through
// the line buffer read, the column minimum into the queue and the window minimum
// into the output register. Pixel (r,c) yields result (r-1,c-1) and, at the row end,
// (r-1,width-1); after all rows, width drain beats yield the bottom row. The line
// buffer needs no clearing after reset: entries not yet written in a frame only reach
// border results, which are forced to zero. Any register write restarts the frame.
module image_min_filter_3x3_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  imf_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output imf_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [imf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [imf_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic                       q_push;
   imf_pkg::job_type           q_push_job;
   logic                       q_pop;
   imf_pkg::job_type           q_head;
   logic                       q_empty;
   logic [imf_pkg::QCNT_W-1:0] q_count;

   imf_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_count    (q_count),
      .q_push     (q_push),
      .q_push_job (q_push_job)
   );

   imf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .count    (q_count)
   );

   imf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
